[hw/rtl/crt_beam_sync_tracker_top_macros.svh]
// Assertion macros used by the CRT beam tracker checker.
`ifndef CRT_BEAM_SYNC_TRACKER_TOP_MACROS_SVH
`define CRT_BEAM_SYNC_TRACKER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CBST_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbst: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define CBST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbst: next-cycle check failed");

`endif

[hw/rtl/cbst_pkg.sv]
// Types, constants and beam update functions of the CRT beam sync tracker.
`timescale 1ns / 1ps
`default_nettype none
package cbst_pkg;

   // Beam constants
   localparam int FIELD_OVERRUN_LINES = 30;
   localparam int LINE_OVERRUN_CYCLES = 1;
   localparam int MAX_RESULTS         = 8;
   localparam int COUNT_W             = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W               = $clog2(MAX_RESULTS);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_RESULTS);
   localparam logic [9:0]  LINE_LIMIT   = 10'd511;
   localparam logic [7:0]  LEVEL_WHITE  = 8'hff;
   localparam logic [7:0]  LEVEL_BLACK  = 8'h00;

   // Input actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_SYNC  = 2'd1;
   localparam logic [1:0] ACT_LEVEL = 2'd2;
   localparam logic [1:0] ACT_BYTE  = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_SPAN = 2'd0;
   localparam logic [1:0] KIND_FILL = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_CYCLES_PER_LINE   = 3'd0;
   localparam logic [2:0] REG_VISIBLE_CYCLES    = 3'd1;
   localparam logic [2:0] REG_LINES_PER_FIELD   = 3'd2;
   localparam logic [2:0] REG_VISIBLE_LINES     = 3'd3;
   localparam logic [2:0] REG_VSYNC_THRESHOLD   = 3'd4;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] span_x;
      logic [8:0]  span_y;
      logic [11:0] span_length;
      logic [7:0]  pixel_level;
      logic        field_even;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [10:0] cycles_per_line;
      logic [10:0] visible_cycles_per_line;
      logic [8:0]  lines_per_field;
      logic [8:0]  visible_lines_per_field;
      logic [12:0] vsync_charge_threshold;
   } cfg_type;

   typedef struct packed {
      logic [11:0] column;
      logic [8:0]  line;
      logic [7:0]  level;
      logic        sync_active;
      logic [12:0] charge;
      logic        next_field_even;
   } beam_type;

   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] list;
      logic [COUNT_W-1:0]        count;
   } batch_type;

   typedef struct packed {
      beam_type  beam;
      batch_type batch;
   } work_type;

   // Line length with zero read as one
   function automatic logic [10:0] f_line_len(cfg_type c);
      return (c.cycles_per_line == '0) ? 11'd1 : c.cycles_per_line;
   endfunction

   // Display width: line length rounded up to a multiple of four
   function automatic logic [11:0] f_disp_w(cfg_type c);
      logic [11:0] sum;
      sum = {1'b0, f_line_len(c)} + 12'd3;
      return {sum[11:2], 2'b00};
   endfunction

   // Append one result to the batch, dropping it once the batch is full
   function automatic work_type f_emit(work_type w, logic [1:0] kind, logic [11:0] x,
                                       logic [8:0] y, logic [11:0] len, logic [7:0] lvl,
                                       logic even);
      rsp_type r;
      r             = '0;
      r.kind        = kind;
      r.span_x      = x[10:0];
      r.span_y      = y;
      r.span_length = len;
      r.pixel_level = lvl;
      r.field_even  = even;
      if (w.batch.count < MAX_COUNT) begin
         w.batch.list[w.batch.count[IDX_W-1:0]] = r;
         w.batch.count = w.batch.count + COUNT_W'(1);
      end
      return w;
   endfunction

   // Close the field: fill the rest, report it, pick the next parity
   function automatic work_type f_new_field(work_type w, cfg_type c);
      logic [10:0] ll;
      logic [11:0] dw;
      logic [12:0] three;
      ll    = f_line_len(c);
      dw    = f_disp_w(c);
      three = {2'b00, ll} + {1'b0, ll, 1'b0};
      if (w.beam.line < c.lines_per_field && w.beam.column < dw) begin
         w = f_emit(w, KIND_FILL, w.beam.column, w.beam.line, 12'd0, w.beam.level, 1'b0);
      end
      if (w.beam.line != '0) begin
         w = f_emit(w, KIND_DONE, 12'd0, 9'd0, 12'd0, 8'd0, w.beam.next_field_even);
      end
      w.beam.line = '0;
      w.beam.next_field_even = (w.beam.column < {3'b000, ll[10:2]}) ||
                               (w.beam.column > {1'b0, three[12:2]});
      return w;
   endfunction

   // Finish the line with one span to the display edge and step down, closing the field past the overrun
   function automatic work_type f_new_line(work_type w, cfg_type c);
      logic [11:0] dw;
      logic [9:0]  nl;
      dw = f_disp_w(c);
      if (w.beam.column < dw && w.beam.line < c.lines_per_field) begin
         w = f_emit(w, KIND_SPAN, w.beam.column, w.beam.line, dw - w.beam.column,
                    w.beam.level, 1'b0);
      end
      w.beam.column = '0;
      nl = {1'b0, w.beam.line} + 10'd1;
      w.beam.line = nl[8:0];
      if (nl >= ({1'b0, c.lines_per_field} + 10'(FIELD_OVERRUN_LINES)) ||
          nl >= LINE_LIMIT) begin
         w = f_new_field(w, c);
      end
      return w;
   endfunction

   // Advance the beam by one pixel cycle
   function automatic work_type f_beam_tick(work_type w, cfg_type c);
      logic [11:0] dw;
      dw = f_disp_w(c);
      if (w.beam.column >= ({1'b0, f_line_len(c)} + 12'(LINE_OVERRUN_CYCLES))) begin
         w = f_new_line(w, c);
      end
      if (w.beam.line < c.lines_per_field && w.beam.column < dw) begin
         w = f_emit(w, KIND_SPAN, w.beam.column, w.beam.line, 12'd1, w.beam.level, 1'b0);
      end
      w.beam.column = w.beam.column + 12'd1;
      return w;
   endfunction

   // Vertical sync only counts below the visible lines
   function automatic work_type f_vsync_seen(work_type w, cfg_type c);
      if (w.beam.line > c.visible_lines_per_field) begin
         w = f_new_field(w, c);
      end
      return w;
   endfunction

   // One tick with the vertical sync charge
   function automatic work_type f_tick(work_type w, cfg_type c);
      logic [12:0] thr;
      thr = (c.vsync_charge_threshold == '0) ? 13'd1 : c.vsync_charge_threshold;
      if (!w.beam.sync_active) begin
         if (w.beam.charge != '0) begin
            w.beam.charge = w.beam.charge - 13'd1;
         end
         w = f_beam_tick(w, c);
      end else begin
         if (w.beam.charge >= thr) begin
            w = f_vsync_seen(w, c);
            w.beam.charge = '0;
         end
         if (({1'b0, w.beam.charge} + 14'd1) >= {1'b0, thr}) begin
            w = f_beam_tick(w, c);
            w = f_vsync_seen(w, c);
            w.beam.charge = '0;
         end else begin
            w.beam.charge = w.beam.charge + 13'd1;
            w = f_beam_tick(w, c);
         end
      end
      return w;
   endfunction

   // Draw up to eight one-bit pixels, merging equal runs into spans
   function automatic work_type f_byte(work_type w, cfg_type c, logic [7:0] v);
      logic [11:0] dw;
      logic [11:0] run_x;
      logic [3:0]  run_len;
      logic [7:0]  run_lvl;
      logic [7:0]  px;
      logic        stop;
      int          i;
      dw      = f_disp_w(c);
      run_x   = '0;
      run_len = '0;
      run_lvl = '0;
      px      = '0;
      stop    = 1'b0;
      if (!((v == LEVEL_BLACK && w.beam.level == LEVEL_BLACK) ||
            (v == LEVEL_WHITE && w.beam.level == LEVEL_WHITE))) begin
         w.beam.sync_active = 1'b0;
         if (w.beam.line < c.lines_per_field) begin
            for (i = 0; i < 8; i++) begin
               if (!stop) begin
                  if (w.beam.column >= dw) begin
                     stop = 1'b1;
                  end else begin
                     px = v[7-i] ? LEVEL_WHITE : LEVEL_BLACK;
                     if (run_len != '0 && px != run_lvl) begin
                        w = f_emit(w, KIND_SPAN, run_x, w.beam.line, {8'd0, run_len},
                                   run_lvl, 1'b0);
                        run_len = '0;
                     end
                     if (run_len == '0) begin
                        run_x   = w.beam.column;
                        run_lvl = px;
                     end
                     run_len       = run_len + 4'd1;
                     w.beam.column = w.beam.column + 12'd1;
                  end
               end
            end
            if (run_len != '0) begin
               w = f_emit(w, KIND_SPAN, run_x, w.beam.line, {8'd0, run_len}, run_lvl, 1'b0);
            end
         end
      end
      return w;
   endfunction

   // Whole update of the beam for one input beat
   function automatic work_type f_step(beam_type b, req_type r, cfg_type c);
      work_type w;
      w.beam  = b;
      w.batch = '0;
      case (r.action)
         ACT_TICK: begin
            w = f_tick(w, c);
         end
         ACT_SYNC: begin
            if (!w.beam.sync_active) begin
               w.beam.sync_active = 1'b1;
               if (w.beam.column > {1'b0, c.visible_cycles_per_line}) begin
                  w = f_new_line(w, c);
               end
               w.beam.level = LEVEL_BLACK;
            end
         end
         ACT_LEVEL: begin
            if (w.beam.level != r.value || w.beam.sync_active) begin
               w.beam.sync_active = 1'b0;
               w.beam.level       = r.value;
            end
         end
         default: begin
            w = f_byte(w, c, r.value);
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/cbst_csr.sv]
// Configuration registers of the CRT beam sync tracker behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module cbst_csr
   import cbst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_beat;

   assign reg_index = paddr[4:2];
   assign wr_beat   = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Update the addressed register on a write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (reg_index)
            REG_CYCLES_PER_LINE: cfg_in.cycles_per_line         = pwdata[10:0];
            REG_VISIBLE_CYCLES:  cfg_in.visible_cycles_per_line = pwdata[10:0];
            REG_LINES_PER_FIELD: cfg_in.lines_per_field         = pwdata[8:0];
            REG_VISIBLE_LINES:   cfg_in.visible_lines_per_field = pwdata[8:0];
            REG_VSYNC_THRESHOLD: cfg_in.vsync_charge_threshold  = pwdata[12:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_line         <= 11'd256;
         cfg_ff.visible_cycles_per_line <= 11'd207;
         cfg_ff.lines_per_field         <= 9'd312;
         cfg_ff.visible_lines_per_field <= 9'd288;
         cfg_ff.vsync_charge_threshold  <= 13'd588;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (reg_index)
         REG_CYCLES_PER_LINE: prdata = CSR_DATA_W'(cfg_ff.cycles_per_line);
         REG_VISIBLE_CYCLES:  prdata = CSR_DATA_W'(cfg_ff.visible_cycles_per_line);
         REG_LINES_PER_FIELD: prdata = CSR_DATA_W'(cfg_ff.lines_per_field);
         REG_VISIBLE_LINES:   prdata = CSR_DATA_W'(cfg_ff.visible_lines_per_field);
         REG_VSYNC_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.vsync_charge_threshold);
         default:             prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/cbst_core.sv]
// Input register, beam state and the combinational beam update.
`timescale 1ns / 1ps
`default_nettype none
module cbst_core
   import cbst_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_data,
   output logic           batch_valid,
   input  wire logic      batch_ready,
   output batch_type      batch
);

   logic     valid_ff;
   logic     valid_in;
   req_type  data_ff;
   req_type  data_in;
   beam_type beam_ff;
   beam_type beam_in;
   work_type work;
   logic     advance;

   // Compute the beam update and its results from the held beat
   always_comb begin
      work = f_step(beam_ff, data_ff, cfg);
   end

   assign advance     = valid_ff && batch_ready;
   assign req_ready   = !valid_ff || batch_ready;
   assign batch_valid = valid_ff;
   assign batch       = work.batch;

   // Hold the beat until its results move on; commit the beam state then
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      beam_in  = beam_ff;
      if (advance) begin
         beam_in  = work.beam;
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beam_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beam_ff  <= beam_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

[hw/rtl/cbst_rsp_buf.sv]
// Result register bank that hands out one batch entry per beat.
`timescale 1ns / 1ps
`default_nettype none
module cbst_rsp_buf
   import cbst_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      batch_valid,
   output logic           batch_ready,
   input  wire batch_type batch,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   rsp_type [MAX_RESULTS-1:0] list_ff;
   rsp_type [MAX_RESULTS-1:0] list_in;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic [IDX_W-1:0]          index_ff;
   logic [IDX_W-1:0]          index_in;
   logic                      is_last;
   logic                      take_new;

   assign is_last     = (COUNT_W'(index_ff) + COUNT_W'(1)) == count_ff;
   assign rsp_valid   = count_ff != '0;
   assign take_new    = (count_ff == '0) || (rsp_ready && is_last);
   assign batch_ready = take_new;

   // Show the current entry, flagging the final one of its batch
   always_comb begin
      rsp_data      = list_ff[index_ff];
      rsp_data.last = is_last;
   end

   // Load a new batch once the old one drains, else advance on each beat
   always_comb begin
      list_in  = list_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (take_new) begin
         index_in = '0;
         if (batch_valid) begin
            list_in  = batch.list;
            count_in = batch.count;
         end else begin
            count_in = '0;
         end
      end else if (rsp_valid && rsp_ready) begin
         index_in = index_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
   end

endmodule
`default_nettype wire

[hw/rtl/crt_beam_sync_tracker_top.sv]
// CRT beam sync tracker top level: register port, beam core and result stage.
//
// The tracker follows a CRT beam driven by composite video: tick, sync start,
// level and one-bit byte beats move the beam, and the writes to the display
// come out as span, fill and field-done results, several per beat where needed,
// with last marking the final one. A beat is registered, updated by combinational
// logic and its results loaded into the result register, from which the first
// result is offered. Beats that give at most one result stream at one per clock
// while rsp_ready is held; a beat with n results (up to eight, as from a one-bit byte,
// or from a tick or sync that closes a line and a field) holds the result register
// until all n are taken, and new beats wait then. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none
module crt_beam_sync_tracker_top
   import cbst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type   cfg;
   batch_type batch;
   logic      batch_valid;
   logic      batch_ready;

   cbst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbst_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .batch_valid (batch_valid),
      .batch_ready (batch_ready),
      .batch       (batch)
   );

   cbst_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .batch_valid (batch_valid),
      .batch_ready (batch_ready),
      .batch       (batch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

[hw/rtl/cbst_checker.sv]
// Port-level checks of the CRT beam sync tracker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "crt_beam_sync_tracker_top_macros.svh"
module cbst_checker
   import cbst_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire req_type               req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_type               rsp_data,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [CSR_DATA_W-1:0] pwdata,
   input wire logic [CSR_DATA_W-1:0] prdata,
   input wire logic                  pready
);

   // Come out of reset empty and ready for a beat
   `CBST_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && req_ready)

   // Field-done results carry no position, length or level
   `CBST_ASSERT_NOW(a_done_clean, rsp_valid && rsp_data.kind == KIND_DONE, rsp_data.span_x == '0 && rsp_data.span_y == '0 && rsp_data.span_length == '0 && rsp_data.pixel_level == '0)

   // Span writes are never empty and never carry a parity
   `CBST_ASSERT_NOW(a_span_len, rsp_valid && rsp_data.kind == KIND_SPAN, rsp_data.span_length != '0 && !rsp_data.field_even)

   // Hold a stalled result beat
   `CBST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Register port never waits
   `CBST_ASSERT_NOW(a_pready, psel && penable, pready)

endmodule

bind crt_beam_sync_tracker_top cbst_checker u_checker (.*);
`default_nettype wire
